// ===== hw/rtl/rycc_pkg.sv =====
package rycc_pkg;

   // Block geometry.
   localparam int BLOCK_SIDE = 8;
   localparam int PIX_COUNT  = BLOCK_SIDE * BLOCK_SIDE;
   localparam int IDX_W      = $clog2(PIX_COUNT);
   localparam int SIDE_W     = $clog2(BLOCK_SIDE);

   // Chroma quads: only the complete 2x2 quads of the block.
   localparam int QSIDE  = BLOCK_SIDE / 2;
   localparam int QCOUNT = QSIDE * QSIDE;
   localparam int QIDX_W = (QCOUNT > 1) ? $clog2(QCOUNT) : 1;
   localparam int QCOL_W = (QSIDE > 1) ? $clog2(QSIDE) : 1;

   // Fixed-point formats.
   localparam int COEF_FRAC_BITS = 16;
   localparam int PIX_W     = 8;
   localparam int Q88_W     = 16;
   localparam int COEF_W    = COEF_FRAC_BITS;
   localparam int PROD_W    = COEF_W + PIX_W;
   localparam int ACC_W     = COEF_FRAC_BITS + 10;
   localparam int OUT_SHIFT = COEF_FRAC_BITS - 8;
   localparam int PAIR_W    = Q88_W + 1;
   localparam int QSUM_W    = Q88_W + 2;

   // Coefficients: floor(c * 2^COEF_FRAC_BITS), c given in millionths.
   localparam logic [63:0] MICRO = 64'd1000000;
   localparam logic [COEF_W-1:0] C_Y_R  = COEF_W'((64'd299000 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_Y_G  = COEF_W'((64'd587000 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_Y_B  = COEF_W'((64'd114000 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_CB_R = COEF_W'((64'd168736 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_CB_G = COEF_W'((64'd331264 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_HALF = COEF_W'((64'd500000 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_CR_G = COEF_W'((64'd418688 << COEF_FRAC_BITS) / MICRO);
   localparam logic [COEF_W-1:0] C_CR_B = COEF_W'((64'd81312 << COEF_FRAC_BITS) / MICRO);
   localparam logic [ACC_W-1:0]  CHROMA_OFFSET = ACC_W'(128) << COEF_FRAC_BITS;

   // Channel payloads.
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_data_type;

   typedef struct packed {
      logic [Q88_W-1:0] luma;
      logic [Q88_W-1:0] blue_chroma;
      logic [Q88_W-1:0] red_chroma;
      logic             last_of_block;
   } rsp_data_type;

   // One converted pixel as kept in the block store.
   typedef struct packed {
      logic [Q88_W-1:0] luma;
      logic [Q88_W-1:0] cb;
      logic [Q88_W-1:0] cr;
   } pix_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic fill_en;
      logic emit_en;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic fill_last;
      logic pipe_busy;
      logic emit_done;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Shift a nonnegative sum down to Q8.8 and saturate it to 16 bits.
   function automatic logic [Q88_W-1:0] q88_sat(input logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0] v;
      v = acc >> OUT_SHIFT;
      if (|v[ACC_W-1:Q88_W]) begin
         return {Q88_W{1'b1}};
      end
      return v[Q88_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/rgb_to_ycbcr_420_block.sv =====
// Takes one pixel per cycle while filling a block of 64; the conversion pipe is three stages.
// After the 64th pixel the input stalls while the conversion pipe drains and while the block
// store is read out, one result per cycle whenever the output is not stalled.
// Reset is synchronous: it empties the pipe, restarts the block and enables chroma averaging;
// the pixel and quad stores are not cleared.
module rgb_to_ycbcr_420_block (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rycc_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rycc_pkg::rsp_data_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);
   import rycc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          avg_enable_ff, avg_enable_in;

   // Chroma averaging enable register.
   assign csr_ready = 1'b1;

   always_comb begin
      avg_enable_in = avg_enable_ff;
      if (csr_valid && csr_ready) begin
         avg_enable_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_enable_ff <= 1'b1;
      end else begin
         avg_enable_ff <= avg_enable_in;
      end
   end

   rycc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rycc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .avg_enable (avg_enable_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // Filling and reading out never overlap.
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_en && cmd.emit_en))
      else $error("fill and emit commanded together");

   // The block is read out only after every pixel has reached the store.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> !status.pipe_busy)
      else $error("emission started with the conversion pipe still busy");

   // After the last read of a block, the next block may start filling.
   a_refill: assert property (@(posedge clock) disable iff (reset)
      status.emit_done |=> (cmd.fill_en && !req_stall))
      else $error("input not reopened after the last read of a block");
`endif

endmodule

// ===== hw/rtl/rycc_ctrl.sv =====
module rycc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rycc_pkg::dp_status_type status,
   output rycc_pkg::ctl_cmd_type  cmd
);
   import rycc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state: fill the block, let the conversion pipe drain, then emit it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_valid && status.fill_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // Outputs decoded from the state alone.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_FILL: begin
            cmd.fill_en = 1'b1;
            req_stall   = 1'b0;
         end
         ST_DRAIN: begin
            req_stall = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_en = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/rycc_dpath.sv =====
module rycc_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  rycc_pkg::ctl_cmd_type  cmd,
   output rycc_pkg::dp_status_type status,
   input  logic                   avg_enable,
   input  logic                   req_valid,
   input  rycc_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rycc_pkg::rsp_data_type rsp_data
);
   import rycc_pkg::*;

   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(PIX_COUNT - 1);
   localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(BLOCK_SIDE - 1);
   localparam logic [SIDE_W:0]   QUAD_EDGE = (SIDE_W + 1)'(2 * QSIDE);

   // Address of the 2x2 quad that holds a pixel.
   function automatic logic [QIDX_W-1:0] quad_addr(input logic [SIDE_W-1:0] row,
                                                   input logic [SIDE_W-1:0] col);
      logic [QIDX_W+SIDE_W-1:0] addr;
      addr = (QIDX_W + SIDE_W)'(row >> 1) * (QIDX_W + SIDE_W)'(QSIDE)
           + (QIDX_W + SIDE_W)'(col >> 1);
      return addr[QIDX_W-1:0];
   endfunction

   logic accept;
   logic issue;
   logic out_adv;

   // Fill position.
   logic [IDX_W-1:0]  fill_idx_ff, fill_idx_in;
   logic [SIDE_W-1:0] fill_row_ff, fill_row_in;
   logic [SIDE_W-1:0] fill_col_ff, fill_col_in;

   // Stage A: products.
   logic              a_v_ff, a_v_in;
   logic [IDX_W-1:0]  a_idx_ff;
   logic [SIDE_W-1:0] a_row_ff, a_col_ff;
   logic [PROD_W-1:0] m_yr_ff, m_yg_ff, m_yb_ff;
   logic [PROD_W-1:0] m_cbr_ff, m_cbg_ff, m_cbb_ff;
   logic [PROD_W-1:0] m_crr_ff, m_crg_ff, m_crb_ff;

   // Stage B: sums in Q8.8.
   logic              b_v_ff, b_v_in;
   logic [IDX_W-1:0]  b_idx_ff;
   logic [SIDE_W-1:0] b_row_ff, b_col_ff;
   pix_entry_type     b_pix_ff, b_pix_in;
   logic [ACC_W-1:0]  cb_base, cb_neg, cr_base, cr_neg;

   // Stage C: block store and quad averaging.
   pix_entry_type     pix_mem [PIX_COUNT];
   logic [Q88_W-1:0]  quad_cb_mem [QCOUNT];
   logic [Q88_W-1:0]  quad_cr_mem [QCOUNT];
   logic [Q88_W-1:0]  hold_cb_ff, hold_cr_ff;
   logic [PAIR_W-1:0] pair_cb_ff [QSIDE];
   logic [PAIR_W-1:0] pair_cr_ff [QSIDE];
   logic [QCOL_W-1:0] c_pidx;
   logic [PAIR_W-1:0] c_pair_cb, c_pair_cr;
   logic [QSUM_W-1:0] c_quad_cb, c_quad_cr;

   // Emission: read stage and output register.
   logic [IDX_W-1:0]  em_idx_ff, em_idx_in;
   logic [SIDE_W-1:0] em_row_ff, em_row_in;
   logic [SIDE_W-1:0] em_col_ff, em_col_in;
   logic              em_inq;
   logic              rd_v_ff, rd_v_in;
   pix_entry_type     rd_pix_ff;
   logic [Q88_W-1:0]  rd_qcb_ff, rd_qcr_ff;
   logic              rd_inq_ff, rd_last_ff;
   logic              out_v_ff, out_v_in;
   rsp_data_type      out_data_ff, out_data_in;

   assign accept  = req_valid && cmd.fill_en;
   assign out_adv = !out_v_ff || !rsp_stall;
   assign issue   = cmd.emit_en && (!rd_v_ff || out_adv);

   assign status.fill_last = (fill_idx_ff == IDX_LAST);
   assign status.pipe_busy = a_v_ff || b_v_ff;
   assign status.emit_done = issue && (em_idx_ff == IDX_LAST);

   // Raster position of the next pixel to arrive.
   always_comb begin
      fill_idx_in = fill_idx_ff;
      fill_row_in = fill_row_ff;
      fill_col_in = fill_col_ff;
      if (accept) begin
         fill_idx_in = (fill_idx_ff == IDX_LAST) ? '0 : fill_idx_ff + 1'b1;
         if (fill_col_ff == SIDE_LAST) begin
            fill_col_in = '0;
            fill_row_in = (fill_row_ff == SIDE_LAST) ? '0 : fill_row_ff + 1'b1;
         end else begin
            fill_col_in = fill_col_ff + 1'b1;
         end
      end
   end

   // Stage B arithmetic: luma sum, chroma offset and difference, saturation.
   always_comb begin
      cb_base = CHROMA_OFFSET + ACC_W'(m_cbb_ff);
      cb_neg  = ACC_W'(m_cbr_ff) + ACC_W'(m_cbg_ff);
      cr_base = CHROMA_OFFSET + ACC_W'(m_crr_ff);
      cr_neg  = ACC_W'(m_crg_ff) + ACC_W'(m_crb_ff);
      b_pix_in.luma = q88_sat(ACC_W'(m_yr_ff) + ACC_W'(m_yg_ff) + ACC_W'(m_yb_ff));
      b_pix_in.cb   = (cb_neg > cb_base) ? '0 : q88_sat(cb_base - cb_neg);
      b_pix_in.cr   = (cr_neg > cr_base) ? '0 : q88_sat(cr_base - cr_neg);
   end

   // Quad sums: horizontal pair first, then the pair of the row above.
   always_comb begin
      c_pidx    = QCOL_W'(b_col_ff >> 1);
      c_pair_cb = PAIR_W'(hold_cb_ff) + PAIR_W'(b_pix_ff.cb);
      c_pair_cr = PAIR_W'(hold_cr_ff) + PAIR_W'(b_pix_ff.cr);
      c_quad_cb = QSUM_W'(pair_cb_ff[c_pidx]) + QSUM_W'(c_pair_cb);
      c_quad_cr = QSUM_W'(pair_cr_ff[c_pidx]) + QSUM_W'(c_pair_cr);
   end

   // Raster position of the next result to read out.
   always_comb begin
      em_idx_in = em_idx_ff;
      em_row_in = em_row_ff;
      em_col_in = em_col_ff;
      if (issue) begin
         em_idx_in = (em_idx_ff == IDX_LAST) ? '0 : em_idx_ff + 1'b1;
         if (em_col_ff == SIDE_LAST) begin
            em_col_in = '0;
            em_row_in = (em_row_ff == SIDE_LAST) ? '0 : em_row_ff + 1'b1;
         end else begin
            em_col_in = em_col_ff + 1'b1;
         end
      end
      em_inq = ({1'b0, em_row_ff} < QUAD_EDGE) && ({1'b0, em_col_ff} < QUAD_EDGE);
   end

   // Valid bits of the pipe stages; the read stage and output register move together.
   always_comb begin
      a_v_in = accept;
      b_v_in = a_v_ff;
      if (issue) begin
         rd_v_in = 1'b1;
      end else if (out_adv) begin
         rd_v_in = 1'b0;
      end else begin
         rd_v_in = rd_v_ff;
      end
      out_v_in = out_adv ? rd_v_ff : out_v_ff;
   end

   // Result selection: quad average where enabled and the pixel has a full quad.
   always_comb begin
      out_data_in.luma          = rd_pix_ff.luma;
      out_data_in.blue_chroma   = (avg_enable && rd_inq_ff) ? rd_qcb_ff : rd_pix_ff.cb;
      out_data_in.red_chroma    = (avg_enable && rd_inq_ff) ? rd_qcr_ff : rd_pix_ff.cr;
      out_data_in.last_of_block = rd_last_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_idx_ff <= '0;
         fill_row_ff <= '0;
         fill_col_ff <= '0;
         em_idx_ff   <= '0;
         em_row_ff   <= '0;
         em_col_ff   <= '0;
         a_v_ff      <= 1'b0;
         b_v_ff      <= 1'b0;
         rd_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         fill_idx_ff <= fill_idx_in;
         fill_row_ff <= fill_row_in;
         fill_col_ff <= fill_col_in;
         em_idx_ff   <= em_idx_in;
         em_row_ff   <= em_row_in;
         em_col_ff   <= em_col_in;
         a_v_ff      <= a_v_in;
         b_v_ff      <= b_v_in;
         rd_v_ff     <= rd_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   // Stage A: one multiplier per product term (C_HALF feeds two), straight from the input item.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_idx_ff <= fill_idx_ff;
         a_row_ff <= fill_row_ff;
         a_col_ff <= fill_col_ff;
         m_yr_ff  <= PROD_W'(C_Y_R) * PROD_W'(req_data.red);
         m_yg_ff  <= PROD_W'(C_Y_G) * PROD_W'(req_data.green);
         m_yb_ff  <= PROD_W'(C_Y_B) * PROD_W'(req_data.blue);
         m_cbr_ff <= PROD_W'(C_CB_R) * PROD_W'(req_data.red);
         m_cbg_ff <= PROD_W'(C_CB_G) * PROD_W'(req_data.green);
         m_cbb_ff <= PROD_W'(C_HALF) * PROD_W'(req_data.blue);
         m_crr_ff <= PROD_W'(C_HALF) * PROD_W'(req_data.red);
         m_crg_ff <= PROD_W'(C_CR_G) * PROD_W'(req_data.green);
         m_crb_ff <= PROD_W'(C_CR_B) * PROD_W'(req_data.blue);
      end
   end

   // Stage B payload.
   always_ff @(posedge clock) begin
      if (a_v_ff) begin
         b_idx_ff <= a_idx_ff;
         b_row_ff <= a_row_ff;
         b_col_ff <= a_col_ff;
         b_pix_ff <= b_pix_in;
      end
   end

   // Stage C: store the pixel and build the quad averages as the block arrives.
   always_ff @(posedge clock) begin
      if (b_v_ff) begin
         pix_mem[b_idx_ff] <= b_pix_ff;
         if (!b_col_ff[0]) begin
            hold_cb_ff <= b_pix_ff.cb;
            hold_cr_ff <= b_pix_ff.cr;
         end else if (!b_row_ff[0]) begin
            pair_cb_ff[c_pidx] <= c_pair_cb;
            pair_cr_ff[c_pidx] <= c_pair_cr;
         end else begin
            quad_cb_mem[quad_addr(b_row_ff, b_col_ff)] <= c_quad_cb[QSUM_W-1:2];
            quad_cr_mem[quad_addr(b_row_ff, b_col_ff)] <= c_quad_cr[QSUM_W-1:2];
         end
      end
   end

   // Registered reads of the block store and the quad store.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_pix_ff  <= pix_mem[em_idx_ff];
         rd_qcb_ff  <= quad_cb_mem[quad_addr(em_row_ff, em_col_ff)];
         rd_qcr_ff  <= quad_cr_mem[quad_addr(em_row_ff, em_col_ff)];
         rd_inq_ff  <= em_inq;
         rd_last_ff <= (em_idx_ff == IDX_LAST);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_adv && rd_v_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== test/rgb_to_ycbcr_420_block_test.sv =====
`timescale 1ns / 100ps

module rgb_to_ycbcr_420_block_test;
   import rycc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int CORNER_COUNT  = 12;

   // Corner pixels as {red, green, blue}: black, white, primaries, secondaries,
   // alternating bit patterns, mid gray and a small odd value.
   localparam logic [23:0] CORNER_PIXELS [CORNER_COUNT] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
      24'hAA55AA, 24'h55AA55, 24'h808080, 24'h010204
   };

   // Tracks converted pixels of the current block and the YCbCr items still owed.
   class ycbcr_block_tracker;
      logic [Q88_W-1:0] luma_store [PIX_COUNT];
      logic [Q88_W-1:0] blue_store [PIX_COUNT];
      logic [Q88_W-1:0] red_store [PIX_COUNT];
      int unsigned      fill_count;
      bit               quad_average_on;
      int unsigned      mismatches;
      rsp_data_type     pending_ycbcr [$];

      function new();
         fill_count      = 0;
         quad_average_on = 1'b1;
         mismatches      = 0;
      endfunction

      // Coefficient in unsigned fixed point, floored from millionths.
      static function longint unsigned coef(input longint unsigned millionths);
         return (millionths << COEF_FRAC_BITS) / 64'd1000000;
      endfunction

      // Drop the extra fraction bits down to Q8.8 and saturate at 16 bits.
      static function logic [Q88_W-1:0] to_q88(input longint unsigned acc);
         longint unsigned v;
         v = acc >> (COEF_FRAC_BITS - 8);
         return (v > 64'd65535) ? 16'hFFFF : v[Q88_W-1:0];
      endfunction

      // Chroma with its offset of 128, floored at zero.
      static function logic [Q88_W-1:0] chroma_q88(input longint unsigned pos,
                                                   input longint unsigned neg);
         longint unsigned base;
         base = (64'd128 << COEF_FRAC_BITS) + pos;
         if (neg > base) begin
            return '0;
         end
         return to_q88(base - neg);
      endfunction

      function int unsigned pending();
         return pending_ycbcr.size();
      endfunction

      // Converts one accepted pixel; the last pixel of a block releases the whole block.
      function void note_pixel(input req_data_type px);
         longint unsigned r, g, b;
         logic [Q88_W+1:0] sum_cb, sum_cr;
         int               a;
         rsp_data_type     item;
         r = px.red;
         g = px.green;
         b = px.blue;
         luma_store[fill_count] = to_q88(coef(299000) * r + coef(587000) * g
                                         + coef(114000) * b);
         blue_store[fill_count] = chroma_q88(coef(500000) * b,
                                             coef(168736) * r + coef(331264) * g);
         red_store[fill_count]  = chroma_q88(coef(500000) * r,
                                             coef(418688) * g + coef(81312) * b);
         fill_count++;
         if (fill_count < PIX_COUNT) begin
            return;
         end
         fill_count = 0;

         // Each complete 2x2 quad shares the truncated mean of its chroma.
         if (quad_average_on) begin
            for (int i = 0; i + 1 < BLOCK_SIDE; i += 2) begin
               for (int j = 0; j + 1 < BLOCK_SIDE; j += 2) begin
                  a = i * BLOCK_SIDE + j;
                  sum_cb = 18'(blue_store[a]) + blue_store[a + 1]
                           + blue_store[a + BLOCK_SIDE] + blue_store[a + BLOCK_SIDE + 1];
                  sum_cr = 18'(red_store[a]) + red_store[a + 1]
                           + red_store[a + BLOCK_SIDE] + red_store[a + BLOCK_SIDE + 1];
                  blue_store[a] = sum_cb[Q88_W+1:2];
                  blue_store[a + 1] = sum_cb[Q88_W+1:2];
                  blue_store[a + BLOCK_SIDE] = sum_cb[Q88_W+1:2];
                  blue_store[a + BLOCK_SIDE + 1] = sum_cb[Q88_W+1:2];
                  red_store[a] = sum_cr[Q88_W+1:2];
                  red_store[a + 1] = sum_cr[Q88_W+1:2];
                  red_store[a + BLOCK_SIDE] = sum_cr[Q88_W+1:2];
                  red_store[a + BLOCK_SIDE + 1] = sum_cr[Q88_W+1:2];
               end
            end
         end

         for (int k = 0; k < PIX_COUNT; k++) begin
            item.luma          = luma_store[k];
            item.blue_chroma   = blue_store[k];
            item.red_chroma    = red_store[k];
            item.last_of_block = (k == PIX_COUNT - 1);
            pending_ycbcr.push_back(item);
         end
      endfunction

      // Compares one delivered item with the oldest one owed.
      function void check_result(input rsp_data_type got);
         rsp_data_type want;
         if (pending_ycbcr.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] unexpected item: Y=%0d Cb=%0d Cr=%0d last=%0b", $realtime,
                        got.luma, got.blue_chroma, got.red_chroma, got.last_of_block);
            end
            return;
         end
         want = pending_ycbcr.pop_front();
         if (got.luma !== want.luma || got.blue_chroma !== want.blue_chroma
             || got.red_chroma !== want.red_chroma
             || got.last_of_block !== want.last_of_block) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] mismatch: expected Y=%0d Cb=%0d Cr=%0d last=%0b", $realtime,
                        want.luma, want.blue_chroma, want.red_chroma, want.last_of_block);
               $display("[%0t]           actual   Y=%0d Cb=%0d Cr=%0d last=%0b", $realtime,
                        got.luma, got.blue_chroma, got.red_chroma, got.last_of_block);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   ycbcr_block_tracker tracker = new();
   int unsigned        cycle_count = 0;
   int unsigned        stall_hold = 0;

   rgb_to_ycbcr_420_block DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: check each accepted item, then alternate open and stalled runs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_result(rsp_data);
      end
      if (stall_hold != 0) begin
         stall_hold = stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   // Components lean toward the rails so that extremes show up inside quads.
   function automatic logic [PIX_W-1:0] pick_component();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) begin
         return '0;
      end else if (roll == 1) begin
         return '1;
      end
      return PIX_W'($urandom_range(0, 255));
   endfunction

   task automatic push_pixel(input req_data_type px);
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      tracker.note_pixel(px);
   endtask

   // Sends one full block; the first corner_n pixels are the fixed corner colors.
   task automatic send_block(input int corner_n, input bit gap_free);
      req_data_type px;
      int           gap;
      for (int k = 0; k < PIX_COUNT; k++) begin
         gap = gap_free ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (k < corner_n) begin
            px = req_data_type'(CORNER_PIXELS[k]);
         end else begin
            px.red   = pick_component();
            px.green = pick_component();
            px.blue  = pick_component();
         end
         push_pixel(px);
      end
      req_valid <= 1'b0;
   endtask

   // Waits for every owed item, then lets the pipe settle.
   task automatic drain_results();
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quad_average(input bit enable);
      csr_valid <= 1'b1;
      csr_data  <= enable;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      tracker.quad_average_on = enable;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Averaging is on out of reset; the first block opens with the corner colors.
      send_block(CORNER_COUNT, 1'b0);
      drain_results();

      write_quad_average(1'b0);
      send_block(0, 1'b0);
      drain_results();

      // Back-to-back pixels with averaging on again.
      write_quad_average(1'b1);
      send_block(0, 1'b1);
      drain_results();

      write_quad_average(1'b0);
      send_block(CORNER_COUNT, 1'b0);
      drain_results();

      if (tracker.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rycc_pkg.sv
hw/rtl/rycc_ctrl.sv
hw/rtl/rycc_dpath.sv
hw/rtl/rgb_to_ycbcr_420_block.sv
test/rgb_to_ycbcr_420_block_test.sv
